// ----- rtl/sbrt_pkg.sv -----
// ----------------------------------------------------------------------------
// sbrt_pkg
// Shared types and codes for the shortest-burst ready table.
// ----------------------------------------------------------------------------
package sbrt_pkg;

    localparam int ID_W     = 16;
    localparam int BURST_W  = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // operation broadcast to every cell while a scan runs
    typedef struct packed {
        logic               search;   // remove or look up
        logic               remove;
        logic [ID_W-1:0]    key;
    } cmd_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               found;
        logic [BURST_W-1:0] found_burst;
        logic               s_v;
        logic [ID_W-1:0]    s_id;
        logic [BURST_W-1:0] s_burst;
        logic               r_v;
        logic [ID_W-1:0]    r_id;
        logic [BURST_W-1:0] r_burst;
    } tok_t;

endpackage

// ----- rtl/sbrt_cell.sv -----
// ----------------------------------------------------------------------------
// sbrt_cell
// One table slot: holds an entry, folds it into the passing scan token and
// takes its lower neighbor's entry when a removal closes the gap.
// ----------------------------------------------------------------------------
module sbrt_cell
    import sbrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  tok_t               tok_in,
    output tok_t               tok_out,
    input  logic               wr_en,
    input  logic [ID_W-1:0]    wr_id,
    input  logic [BURST_W-1:0] wr_burst,
    input  logic               shift_en,
    input  logic               nb_valid,
    input  logic [ID_W-1:0]    nb_id,
    input  logic [BURST_W-1:0] nb_burst,
    output logic               valid,
    output logic [ID_W-1:0]    id,
    output logic [BURST_W-1:0] burst
);

    logic               valid_reg;
    logic [ID_W-1:0]    id_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               after_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic               match;

    always_comb
    begin
        match    = valid_reg && cmd.search && !tok_in.found && (id_reg == cmd.key);
        tok_next = tok_in;
        if (match)
        begin
            tok_next.found = 1'b1;
            if (!cmd.remove)
            begin
                tok_next.found_burst = burst_reg;
            end
        end
        // an entry being removed takes no part in the minimum
        if (valid_reg && !(match && cmd.remove))
        begin
            if (!tok_in.s_v || (burst_reg < tok_in.s_burst))
            begin
                tok_next.r_v     = tok_in.s_v;
                tok_next.r_id    = tok_in.s_id;
                tok_next.r_burst = tok_in.s_burst;
                tok_next.s_v     = 1'b1;
                tok_next.s_id    = id_reg;
                tok_next.s_burst = burst_reg;
            end
            else if (!tok_in.r_v || (burst_reg < tok_in.r_burst))
            begin
                tok_next.r_v     = 1'b1;
                tok_next.r_id    = id_reg;
                tok_next.r_burst = burst_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            after_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (tok_in.active)
            begin
                after_reg <= match || tok_in.found;
            end
            if (wr_en)
            begin
                valid_reg <= 1'b1;
            end
            else if (shift_en && after_reg)
            begin
                valid_reg <= nb_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_reg    <= wr_id;
            burst_reg <= wr_burst;
        end
        else if (shift_en && after_reg)
        begin
            id_reg    <= nb_id;
            burst_reg <= nb_burst;
        end
    end

    assign tok_out = tok_reg;
    assign valid   = valid_reg;
    assign id      = id_reg;
    assign burst   = burst_reg;

endmodule

// ----- rtl/shortest_burst_ready_table_top.sv -----
// ----------------------------------------------------------------------------
// shortest_burst_ready_table_top
// Ready table of client jobs in arrival order with shortest-burst report.
// ----------------------------------------------------------------------------
// Each request is accepted in the idle state, then a scan token walks the row
// of slot cells (one cell per cycle, finding the id and folding in the two
// least bursts). The token leaving the last cell is captured, and the result
// is then registered and the gap of a removed entry closed once the output
// side is free. Inserts are written into the tail slot on acceptance. A new
// request is taken once the previous result is registered, even if it is
// still waiting on the output side, so the table takes no new request before
// it is through with the last one.
module shortest_burst_ready_table_top
    import sbrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // [15:0] client_number, [31:16] burst_length
    input  logic [31:0] s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // [1:0] status, [17:2] found_burst, then entry_count, has_shortest,
    // shortest_id, shortest_burst, runner_up_id, runner_up_burst, zero fill
    output logic [((STATUS_W + 3*BURST_W + 2*ID_W + 1
                    + $clog2(TABLE_DEPTH+1)) + 7) / 8 * 8 - 1:0] m_tdata
);

    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int FIELD_W = STATUS_W + 3*BURST_W + 2*ID_W + 1 + COUNT_W;
    localparam int M_W     = (FIELD_W + 7) / 8 * 8;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic               start_reg;
    cmd_t               cmd_reg;
    logic               full_reg;
    logic [COUNT_W-1:0] count_reg;
    tok_t               tail_reg;
    logic               m_tvalid_reg;
    logic [M_W-1:0]     m_tdata_reg;

    tok_t               tok_in  [TABLE_DEPTH];
    tok_t               tok_out [TABLE_DEPTH];
    logic               c_valid [TABLE_DEPTH];
    logic [ID_W-1:0]    c_id    [TABLE_DEPTH];
    logic [BURST_W-1:0] c_burst [TABLE_DEPTH];

    logic               accept;
    logic               is_insert;
    logic               full_now;
    logic               finish;
    logic               shift_en;
    tok_t               start_tok;

    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;
    logic [ID_W-1:0]     res_s_id, res_r_id;
    logic [BURST_W-1:0]  res_s_b, res_r_b;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_insert = (s_tuser == KIND_INSERT);
    assign full_now  = (count_reg == COUNT_W'(TABLE_DEPTH));
    assign finish    = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign shift_en  = finish && cmd_reg.remove && tail_reg.found;

    always_comb
    begin
        start_tok        = '0;
        start_tok.active = start_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic               nbv;
            logic [ID_W-1:0]    nbi;
            logic [BURST_W-1:0] nbb;

            if (gi == 0)
            begin : g_first
                assign tok_in[gi] = start_tok;
            end
            else
            begin : g_rest
                assign tok_in[gi] = tok_out[gi-1];
            end

            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign nbv = 1'b0;
                assign nbi = '0;
                assign nbb = '0;
            end
            else
            begin : g_inner
                assign nbv = c_valid[gi+1];
                assign nbi = c_id[gi+1];
                assign nbb = c_burst[gi+1];
            end

            sbrt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd_reg),
                .tok_in   (tok_in[gi]),
                .tok_out  (tok_out[gi]),
                .wr_en    (accept && is_insert && (count_reg == COUNT_W'(gi))),
                .wr_id    (s_tdata[ID_W-1:0]),
                .wr_burst (s_tdata[ID_W +: BURST_W]),
                .shift_en (shift_en),
                .nb_valid (nbv),
                .nb_id    (nbi),
                .nb_burst (nbb),
                .valid    (c_valid[gi]),
                .id       (c_id[gi]),
                .burst    (c_burst[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_out[TABLE_DEPTH-1].active)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd_reg.search)
        begin
            res_status = tail_reg.found ? STATUS_OK : STATUS_NOT_FOUND;
        end
        else
        begin
            res_status = full_reg ? STATUS_FULL : STATUS_OK;
        end
        res_count = shift_en ? (count_reg - COUNT_W'(1)) : count_reg;
        res_s_id  = tail_reg.s_v ? tail_reg.s_id    : '0;
        res_s_b   = tail_reg.s_v ? tail_reg.s_burst : '0;
        // a lone entry is its own runner-up
        res_r_id  = tail_reg.r_v ? tail_reg.r_id    : res_s_id;
        res_r_b   = tail_reg.r_v ? tail_reg.r_burst : res_s_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (accept && is_insert && !full_now)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (shift_en)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
            if (finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.search <= !is_insert;
            cmd_reg.remove <= (s_tuser == KIND_REMOVE);
            cmd_reg.key    <= s_tdata[ID_W-1:0];
            full_reg       <= full_now;
        end
        if ((state_reg == ST_SCAN) && tok_out[TABLE_DEPTH-1].active)
        begin
            tail_reg <= tok_out[TABLE_DEPTH-1];
        end
        if (finish)
        begin
            m_tdata_reg <= M_W'({res_r_b, res_r_id, res_s_b, res_s_id,
                                 tail_reg.s_v, res_count,
                                 tail_reg.found_burst, res_status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- test/tb_shortest_burst_ready_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_burst_ready_table_top
// Drives insert, remove and look-up requests into the ready table and checks
// every report against a cycle-free model of the table kept in the bench.
// ----------------------------------------------------------------------------
module tb_shortest_burst_ready_table_top;
    import sbrt_pkg::*;

    localparam int DEPTH          = 16;
    localparam int COUNT_W        = $clog2(DEPTH + 1);
    localparam int OUT_W          = ((STATUS_W + 3*BURST_W + 2*ID_W + 1 + COUNT_W) + 7)
                                    / 8 * 8;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;   // decoded as a look up
    localparam int RANDOM_ITEMS   = 1200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int QUIET_FIRST    = 500;
    localparam int QUIET_LAST     = 700;
    localparam int HOLD_AT        = 900;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [BURST_W-1:0]  runner_up_burst;
        logic [ID_W-1:0]     runner_up_id;
        logic [BURST_W-1:0]  shortest_burst;
        logic [ID_W-1:0]     shortest_id;
        logic                has_shortest;
        logic [COUNT_W-1:0]  entry_count;
        logic [BURST_W-1:0]  found_burst;
        logic [STATUS_W-1:0] status;
    } report_t;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        bit                 typed;
        report_t            want;
    } stim_row_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;
    logic [KIND_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    shortest_burst_ready_table_top #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // bench copy of the table
    logic [ID_W-1:0]    job_id    [DEPTH];
    logic [BURST_W-1:0] job_burst [DEPTH];
    int                 job_count = 0;

    report_t   pending_reports [$];
    stim_row_t directed_rows   [$];
    int        errors      = 0;
    int        rx_reports  = 0;
    int        hold_left   = 0;
    bit        hold_done   = 1'b0;
    int        quiet_ticks = 0;

    // earliest slot holding the least burst, skipping one slot
    function automatic int least_burst_slot(input int skip);
        int best;
        best = -1;
        for (int i = 0; i < job_count; i++) begin
            if (i != skip && (best < 0 || job_burst[i] < job_burst[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic int slot_of_id(input logic [ID_W-1:0] id);
        for (int i = 0; i < job_count; i++)
            if (job_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic report_t apply_table_op(input logic [KIND_W-1:0] kind,
                                               input logic [ID_W-1:0] id,
                                               input logic [BURST_W-1:0] burst);
        report_t r;
        int      k;
        int      s;
        int      q;
        r = '0;
        if (kind == KIND_INSERT) begin
            if (job_count >= DEPTH)
                r.status = STATUS_FULL;
            else
            begin
                job_id[job_count]    = id;
                job_burst[job_count] = burst;
                job_count++;
            end
        end
        else
        begin
            k = slot_of_id(id);
            if (k < 0)
                r.status = STATUS_NOT_FOUND;
            else if (kind == KIND_REMOVE)
            begin
                for (int i = k; i + 1 < job_count; i++)
                begin
                    job_id[i]    = job_id[i + 1];
                    job_burst[i] = job_burst[i + 1];
                end
                job_count--;
            end
            else
                r.found_burst = job_burst[k];
        end
        r.entry_count = COUNT_W'(job_count);
        if (job_count > 0)
        begin
            s = least_burst_slot(-1);
            q = (job_count == 1) ? s : least_burst_slot(s);
            r.has_shortest    = 1'b1;
            r.shortest_id     = job_id[s];
            r.shortest_burst  = job_burst[s];
            r.runner_up_id    = job_id[q];
            r.runner_up_burst = job_burst[q];
        end
        return r;
    endfunction

    function automatic report_t mk_report(input logic [STATUS_W-1:0] status,
                                          input logic [BURST_W-1:0] found,
                                          input int count,
                                          input logic [ID_W-1:0] sid,
                                          input logic [BURST_W-1:0] sb);
        report_t r;
        r                 = '0;
        r.status          = status;
        r.found_burst     = found;
        r.entry_count     = COUNT_W'(count);
        r.has_shortest    = (count > 0);
        r.shortest_id     = sid;
        r.shortest_burst  = sb;
        r.runner_up_id    = sid;
        r.runner_up_burst = sb;
        return r;
    endfunction

    function automatic void add_row(input logic [KIND_W-1:0] kind,
                                    input logic [ID_W-1:0] id,
                                    input logic [BURST_W-1:0] burst,
                                    input bit typed, input report_t want);
        stim_row_t row;
        row.kind  = kind;
        row.id    = id;
        row.burst = burst;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // holds the request until accepted, then records what the table must report
    task automatic offer_request(input logic [KIND_W-1:0] kind,
                                 input logic [ID_W-1:0] id,
                                 input logic [BURST_W-1:0] burst,
                                 input bit may_idle, input bit typed,
                                 input report_t want);
        report_t predicted;
        while (may_idle && $urandom_range(0, 99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {burst, id};
        do @(posedge clk); while (!s_tready);
        predicted = apply_table_op(kind, id, burst);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %h got %h", name, want, got);
            errors++;
        end
    endtask

    // result side: random stall, one long hold-off, one quiet window
    always @(posedge clk)
    begin : report_side
        report_t got;
        report_t want;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && rx_reports >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (rx_reports >= QUIET_FIRST && rx_reports < QUIET_LAST)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 24);

        if (rst_n && m_tvalid && m_tready)
        begin
            rx_reports <= rx_reports + 1;
            got = m_tdata[$bits(report_t)-1:0];
            if (pending_reports.size() == 0)
            begin
                $error("report with nothing outstanding: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("status", want.status, got.status);
                check_field("found_burst", want.found_burst, got.found_burst);
                check_field("entry_count", want.entry_count, got.entry_count);
                check_field("has_shortest", want.has_shortest, got.has_shortest);
                check_field("shortest_id", want.shortest_id, got.shortest_id);
                check_field("shortest_burst", want.shortest_burst, got.shortest_burst);
                check_field("runner_up_id", want.runner_up_id, got.runner_up_id);
                check_field("runner_up_burst", want.runner_up_burst,
                            got.runner_up_burst);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_ticks <= 0;
        else
            quiet_ticks <= quiet_ticks + 1;
        if (quiet_ticks >= WATCHDOG_LIMIT)
        begin
            $display("shortest_burst_ready_table_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        report_t            none;
        report_t            empty;
        report_t            single;
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        int                 roll;
        int                 insert_pct;
        none   = '0;
        empty  = mk_report(STATUS_NOT_FOUND, '0, 0, '0, '0);
        single = mk_report(STATUS_OK, '0, 1, 16'hFFFF, 16'hFFFF);

        // empty table, then a single entry at the top of both ranges
        add_row(KIND_LOOKUP, 16'h0000, 16'hFFFF, 1'b1, empty);
        add_row(KIND_REMOVE, 16'hFFFF, 16'h0000, 1'b1, empty);
        add_row(KIND_SPARE,  16'h0000, 16'h0000, 1'b1, empty);
        add_row(KIND_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, single);
        add_row(KIND_LOOKUP, 16'hFFFF, 16'h0000, 1'b1,
                mk_report(STATUS_OK, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF));
        add_row(KIND_SPARE,  16'hFFFF, 16'h1111, 1'b1,
                mk_report(STATUS_OK, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF));
        // ties on burst zero, duplicate id, remove earliest duplicate
        add_row(KIND_INSERT, 16'h0000, 16'h0000, 1'b0, none);
        add_row(KIND_INSERT, 16'h1234, 16'h0000, 1'b0, none);
        add_row(KIND_INSERT, 16'h0000, 16'h0005, 1'b0, none);
        add_row(KIND_LOOKUP, 16'h0000, 16'h0000, 1'b0, none);
        add_row(KIND_REMOVE, 16'h0000, 16'h0000, 1'b0, none);
        add_row(KIND_LOOKUP, 16'h5555, 16'h0000, 1'b0, none);
        // fill up, refuse one more, then close gaps in the middle and at the head
        for (int i = 0; i < 13; i++)
            add_row(KIND_INSERT, 16'h0100 + 16'(i), 16'h8000 - 16'(3 * i), 1'b0, none);
        add_row(KIND_INSERT, 16'h0007, 16'h0001, 1'b0, none);
        add_row(KIND_REMOVE, 16'h0105, 16'h0000, 1'b0, none);
        add_row(KIND_REMOVE, 16'hFFFF, 16'h0000, 1'b0, none);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_request(directed_rows[i].kind, directed_rows[i].id,
                          directed_rows[i].burst, 1'b1, directed_rows[i].typed,
                          directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // phases push the table toward full, toward empty, and in between
            case ((n / 150) % 4)
                0:       insert_pct = 75;
                2:       insert_pct = 20;
                default: insert_pct = 45;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                kind = KIND_INSERT;
            else if (roll < insert_pct + (100 - insert_pct) / 2)
                kind = KIND_REMOVE;
            else if ($urandom_range(0, 9) == 0)
                kind = KIND_SPARE;
            else
                kind = KIND_LOOKUP;

            roll = $urandom_range(0, 99);
            if (kind != KIND_INSERT && job_count > 0 && roll < 70)
                id = job_id[$urandom_range(0, job_count - 1)];
            else if (roll < 80)
                id = 16'($urandom_range(0, 7));
            else if (roll < 90)
                id = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            else
                id = 16'($urandom);

            roll = $urandom_range(0, 99);
            if (roll < 40)
                burst = 16'($urandom_range(0, 3));
            else if (roll < 80)
                burst = 16'($urandom);
            else
                burst = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;

            offer_request(kind, id, burst, !(n >= QUIET_FIRST && n < QUIET_LAST),
                          1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("shortest_burst_ready_table_top: match");
        else
            $display("shortest_burst_ready_table_top: mismatch");
        $finish;
    end

endmodule
